/* rtl/core/region_table_allocator_unit_macros.svh */
// Assertion macros shared by the region table allocator RTL.
`ifndef REGION_TABLE_ALLOCATOR_UNIT_MACROS_SVH
`define REGION_TABLE_ALLOCATOR_UNIT_MACROS_SVH

// same-cycle implication, reset masked
`define RTAU_ASSERT_NOW(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) else $error(msg);

// next-cycle implication, reset masked
`define RTAU_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

/* rtl/core/rtau_pkg.sv */
// Opcode and status codes of the region table allocator.
package rtau_pkg;

	localparam logic [1:0] OP_ADD      = 2'd0;
	localparam logic [1:0] OP_ALLOC    = 2'd1;
	localparam logic [1:0] OP_ALLOC_AT = 2'd2;
	localparam logic [1:0] OP_RELEASE  = 2'd3;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_ZERO     = 3'd1;
	localparam logic [2:0] ST_NOFIT    = 3'd2;
	localparam logic [2:0] ST_NOTFOUND = 3'd3;
	localparam logic [2:0] ST_FULL     = 3'd4;

endpackage

/* rtl/core/region_table_allocator_unit.sv */
// Region table allocator: first-fit allocate, allocate-at, add and release with merge.
// One transaction at a time. The table sits in a single-port-write, one-read RAM with
// registered read data, so each slot visited needs a read state before it is checked. Add
// checks the new region against the last entry and writes it; allocate and allocate-at scan
// slot by slot, move entries up on a split and then write up to 3 entries; release scans to
// the matching slot and then compacts the whole table, merging adjacent free entries.
// A new transaction is taken once the previous result sits in the output register.
`include "region_table_allocator_unit_macros.svh"

module region_table_allocator_unit
	import rtau_pkg::*;
#(
	parameter int REGION_SLOTS = 32,
	parameter int ADDRESS_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // address[31:0], size[63:32]
	input  logic [1:0]  s_tuser,   // opcode[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // base_out[31:0]
	output logic [2:0]  m_tuser    // status[2:0]
);

	localparam int AW = ADDRESS_BITS;
	localparam int IW = $clog2(REGION_SLOTS);
	localparam int TW = $clog2(REGION_SLOTS + 1);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_DISP   = 4'd1;
	localparam logic [3:0] S_ADDCHK = 4'd2;
	localparam logic [3:0] S_SCRD   = 4'd3;
	localparam logic [3:0] S_SCCHK  = 4'd4;
	localparam logic [3:0] S_SHRD   = 4'd5;
	localparam logic [3:0] S_SHWR   = 4'd6;
	localparam logic [3:0] S_WR     = 4'd7;
	localparam logic [3:0] S_CPRD   = 4'd8;
	localparam logic [3:0] S_CPCHK  = 4'd9;
	localparam logic [3:0] S_CPEND  = 4'd10;
	localparam logic [3:0] S_RESP   = 4'd11;

	typedef struct packed {
		logic          y;
		logic [AW-1:0] e;
		logic [AW-1:0] b;
	} entry_t;

	entry_t mem [REGION_SLOTS];
	entry_t mem_q;
	entry_t rdm;
	entry_t wdata;
	logic   we;
	logic [IW-1:0] waddr, raddr;

	logic [3:0]    state_q;
	logic [1:0]    op_q;
	logic [AW-1:0] a_q, s_q, t_q, base_q;
	logic          ovf_q;
	logic [2:0]    st_q;
	logic [TW-1:0] total_q, k_q, p_q, w_q, widx_q;
	logic [1:0]    inc_q, wcnt_q, wj_q;
	logic [IW-1:0] rel_q;
	entry_t        lst_q [3];
	entry_t        cur_q;
	logic          m_valid_q;
	logic [31:0]   m_data_q;
	logic [2:0]    m_user_q;

	logic [AW:0]   sum;
	logic [AW-1:0] a_in, s_in, len;
	logic          fit_at, lo_cut, hi_cut;
	logic [1:0]    need;
	logic [TW:0]   after_at;

	assign a_in   = AW'(s_tdata[31:0]);
	assign s_in   = AW'(s_tdata[63:32]);
	assign sum    = {1'b0, a_in} + {1'b0, s_in};
	assign len    = mem_q.e - mem_q.b;
	assign lo_cut = a_q > mem_q.b;
	assign hi_cut = t_q < mem_q.e;
	assign fit_at = !mem_q.y && (mem_q.b <= a_q) && (t_q <= mem_q.e);
	assign need   = {1'b0, lo_cut} + {1'b0, hi_cut};
	assign after_at = {1'b0, total_q} + (TW+1)'(need);

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_user_q;

	always_comb begin
		rdm = mem_q;
		if (k_q[IW-1:0] == rel_q) begin
			rdm.y = 1'b0;
		end
	end

	always_comb begin
		raddr = '0;
		we    = 1'b0;
		waddr = '0;
		wdata = mem_q;
		unique case (state_q)
			S_DISP:  raddr = IW'(total_q - TW'(1));
			S_SCRD,
			S_CPRD:  raddr = k_q[IW-1:0];
			S_SHRD:  raddr = IW'(k_q - TW'(1));
			S_SHWR: begin
				we    = 1'b1;
				waddr = IW'(k_q - TW'(1) + TW'(inc_q));
				wdata = mem_q;
			end
			S_WR: begin
				we    = 1'b1;
				waddr = IW'(widx_q + TW'(wj_q));
				wdata = lst_q[wj_q];
			end
			S_CPCHK: begin
				we    = (k_q != '0) &&
					!(!cur_q.y && !rdm.y && (cur_q.e == rdm.b));
				waddr = w_q[IW-1:0];
				wdata = cur_q;
			end
			S_CPEND: begin
				we    = 1'b1;
				waddr = w_q[IW-1:0];
				wdata = cur_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		mem_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			total_q   <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (m_valid_q && m_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						op_q    <= s_tuser;
						a_q     <= a_in;
						s_q     <= s_in;
						t_q     <= sum[AW-1:0];
						ovf_q   <= sum[AW];
						base_q  <= a_in;
						k_q     <= '0;
						w_q     <= '0;
						state_q <= S_DISP;
					end
				end
				S_DISP: begin
					priority if (op_q != OP_RELEASE && s_q == '0) begin
						st_q <= ST_ZERO;
						state_q <= S_RESP;
					end else if (op_q == OP_ADD) begin
						priority if (total_q == TW'(REGION_SLOTS) || ovf_q) begin
							st_q <= ST_FULL;
							state_q <= S_RESP;
						end else if (total_q == '0) begin
							lst_q[0] <= '{y: 1'b0, e: t_q, b: a_q};
							wcnt_q <= 2'd1;
							wj_q   <= '0;
							inc_q  <= 2'd1;
							widx_q <= total_q;
							state_q <= S_WR;
						end else begin
							state_q <= S_ADDCHK;
						end
					end else if (op_q == OP_ALLOC_AT && ovf_q) begin
						st_q <= ST_NOFIT;
						state_q <= S_RESP;
					end else begin
						state_q <= S_SCRD;
					end
				end
				S_ADDCHK: begin
					if (a_q < mem_q.e) begin
						st_q <= ST_FULL;
						state_q <= S_RESP;
					end else begin
						lst_q[0] <= '{y: 1'b0, e: t_q, b: a_q};
						wcnt_q <= 2'd1;
						wj_q   <= '0;
						inc_q  <= 2'd1;
						widx_q <= total_q;
						state_q <= S_WR;
					end
				end
				S_SCRD: begin
					if (k_q == total_q) begin
						st_q <= (op_q == OP_RELEASE) ? ST_NOTFOUND : ST_NOFIT;
						state_q <= S_RESP;
					end else begin
						state_q <= S_SCCHK;
					end
				end
				S_SCCHK: begin
					state_q <= S_SCRD;
					k_q     <= k_q + TW'(1);
					unique case (op_q)
						OP_ALLOC: begin
							if (!mem_q.y && len >= s_q) begin
								if (len == s_q) begin
									lst_q[0] <= '{y: 1'b1, e: mem_q.e, b: mem_q.b};
									wcnt_q <= 2'd1;
									inc_q  <= 2'd0;
									wj_q   <= '0;
									widx_q <= k_q;
									base_q <= mem_q.b;
									state_q <= S_SHRD;
								end else if (total_q != TW'(REGION_SLOTS)) begin
									lst_q[0] <= '{y: 1'b1, e: mem_q.b + s_q, b: mem_q.b};
									lst_q[1] <= '{y: 1'b0, e: mem_q.e, b: mem_q.b + s_q};
									wcnt_q <= 2'd2;
									inc_q  <= 2'd1;
									wj_q   <= '0;
									widx_q <= k_q;
									p_q    <= k_q + TW'(1);
									k_q    <= total_q;
									base_q <= mem_q.b;
									state_q <= S_SHRD;
								end
							end
						end
						OP_ALLOC_AT: begin
							if (fit_at) begin
								if (after_at > (TW+1)'(REGION_SLOTS)) begin
									st_q <= ST_FULL;
									state_q <= S_RESP;
								end else begin
									unique case ({lo_cut, hi_cut})
										2'b00: begin
											lst_q[0] <= '{y: 1'b1, e: t_q, b: a_q};
										end
										2'b01: begin
											lst_q[0] <= '{y: 1'b1, e: t_q, b: a_q};
											lst_q[1] <= '{y: 1'b0, e: mem_q.e, b: t_q};
										end
										2'b10: begin
											lst_q[0] <= '{y: 1'b0, e: a_q, b: mem_q.b};
											lst_q[1] <= '{y: 1'b1, e: t_q, b: a_q};
										end
										default: begin
											lst_q[0] <= '{y: 1'b0, e: a_q, b: mem_q.b};
											lst_q[1] <= '{y: 1'b1, e: t_q, b: a_q};
											lst_q[2] <= '{y: 1'b0, e: mem_q.e, b: t_q};
										end
									endcase
									wcnt_q <= need + 2'd1;
									inc_q  <= need;
									wj_q   <= '0;
									widx_q <= k_q;
									p_q    <= k_q + TW'(1);
									k_q    <= total_q;
									state_q <= S_SHRD;
								end
							end
						end
						default: begin
							if (mem_q.b == a_q) begin
								if (mem_q.y) begin
									rel_q <= k_q[IW-1:0];
									k_q   <= '0;
									state_q <= S_CPRD;
								end else begin
									st_q <= ST_NOTFOUND;
									state_q <= S_RESP;
								end
							end
						end
					endcase
				end
				S_SHRD: begin
					state_q <= (inc_q == '0 || k_q <= p_q) ? S_WR : S_SHWR;
				end
				S_SHWR: begin
					k_q     <= k_q - TW'(1);
					state_q <= S_SHRD;
				end
				S_WR: begin
					wj_q <= wj_q + 2'd1;
					if (wj_q == wcnt_q - 2'd1) begin
						total_q <= total_q + TW'(inc_q);
						st_q    <= ST_OK;
						state_q <= S_RESP;
					end
				end
				S_CPRD: begin
					state_q <= (k_q == total_q) ? S_CPEND : S_CPCHK;
				end
				S_CPCHK: begin
					k_q     <= k_q + TW'(1);
					state_q <= S_CPRD;
					if (k_q == '0) begin
						cur_q <= rdm;
					end else if (!cur_q.y && !rdm.y && (cur_q.e == rdm.b)) begin
						cur_q.e <= rdm.e;
					end else begin
						w_q   <= w_q + TW'(1);
						cur_q <= rdm;
					end
				end
				S_CPEND: begin
					total_q <= w_q + TW'(1);
					st_q    <= ST_OK;
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (!m_valid_q || m_tready) begin
						m_valid_q <= 1'b1;
						m_user_q  <= st_q;
						m_data_q  <= (st_q == ST_OK) ? 32'(base_q) : 32'd0;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`RTAU_ASSERT_NOW(a_total_bound, 1'b1, total_q <= TW'(REGION_SLOTS), "region count overflow")
	`RTAU_ASSERT_NEXT(a_accept_busy, s_tvalid && s_tready, state_q == S_DISP, "accept not dispatched")
	`RTAU_ASSERT_NOW(a_fail_zero, m_tvalid && m_tuser != ST_OK, m_tdata == 32'd0, "nonzero base on error")
	`RTAU_ASSERT_NOW(a_shift_range, state_q == S_SHWR, k_q > p_q, "shift below insert point")

endmodule

/* sim/tb.sv */
// Testbench for region_table_allocator_unit: random and directed table operations checked against a behavioral table.
module tb;
	import rtau_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS = 32;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct packed {
		logic [31:0] base;
		logic [2:0]  status;
	} alloc_result_t;

	class region_scoreboard;
		logic [32:0] rbeg[SLOTS];
		logic [32:0] rend[SLOTS];
		bit          rbusy[SLOTS];
		int          count;
		alloc_result_t pending[$];
		int          errors;

		function void clear();
			count = 0;
			errors = 0;
			for (int k = 0; k < SLOTS; k++) begin
				rbeg[k] = 0;
				rend[k] = 0;
				rbusy[k] = 0;
			end
		endfunction

		function void open_slot(int p, logic [32:0] b, logic [32:0] e, bit bz);
			for (int k = count; k > p; k--) begin
				rbeg[k] = rbeg[k-1];
				rend[k] = rend[k-1];
				rbusy[k] = rbusy[k-1];
			end
			rbeg[p] = b;
			rend[p] = e;
			rbusy[p] = bz;
			count++;
		endfunction

		function void drop_slot(int p);
			for (int k = p; k + 1 < count; k++) begin
				rbeg[k] = rbeg[k+1];
				rend[k] = rend[k+1];
				rbusy[k] = rbusy[k+1];
			end
			count--;
			rbusy[count] = 0;
		endfunction

		function void note_request(logic [1:0] op, logic [31:0] addr, logic [31:0] sz);
			logic [32:0] a, s, t;
			logic [2:0]  st;
			logic [31:0] b;
			int          i, need;
			a = {1'b0, addr};
			s = {1'b0, sz};
			t = a + s;
			b = 0;
			st = ST_OK;
			case (op)
				OP_ADD: begin
					if (s == 0) st = ST_ZERO;
					else if (count >= SLOTS) st = ST_FULL;
					else if (t[32]) st = ST_FULL;
					else if (count > 0 && a < rend[count-1]) st = ST_FULL;
					else begin
						open_slot(count, a, t, 0);
						b = addr;
					end
				end
				OP_ALLOC: begin
					if (s == 0) st = ST_ZERO;
					else begin
						st = ST_NOFIT;
						for (i = 0; i < count; i++) begin
							if (rbusy[i] || rend[i] - rbeg[i] < s) continue;
							if (rend[i] - rbeg[i] == s) begin
								rbusy[i] = 1;
							end else if (count >= SLOTS) begin
								continue;
							end else begin
								t = rend[i];
								rend[i] = rbeg[i] + s;
								rbusy[i] = 1;
								open_slot(i + 1, rbeg[i] + s, t, 0);
							end
							b = rbeg[i][31:0];
							st = ST_OK;
							break;
						end
					end
				end
				OP_ALLOC_AT: begin
					if (s == 0) st = ST_ZERO;
					else if (t[32]) st = ST_NOFIT;
					else begin
						for (i = 0; i < count; i++)
							if (!rbusy[i] && rbeg[i] <= a && t <= rend[i]) break;
						if (i >= count) st = ST_NOFIT;
						else begin
							need = (a > rbeg[i]) + (t < rend[i]);
							if (count + need > SLOTS) st = ST_FULL;
							else begin
								if (a > rbeg[i]) begin
									s = rend[i];
									rend[i] = a;
									open_slot(i + 1, a, s, 0);
									i++;
								end
								if (t < rend[i]) begin
									s = rend[i];
									rend[i] = t;
									open_slot(i + 1, t, s, 0);
								end
								rbusy[i] = 1;
								b = addr;
							end
						end
					end
				end
				default: begin
					for (i = 0; i < count; i++)
						if (rbeg[i] == a) break;
					if (i >= count || !rbusy[i]) st = ST_NOTFOUND;
					else begin
						rbusy[i] = 0;
						i = 0;
						while (i + 1 < count) begin
							if (!rbusy[i] && !rbusy[i+1] && rend[i] == rbeg[i+1]) begin
								rend[i] = rend[i+1];
								drop_slot(i + 1);
							end else i++;
						end
						b = addr;
					end
				end
			endcase
			pending.push_back('{base: b, status: st});
		endfunction

		task report_mismatch(string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_result(logic [31:0] b, logic [2:0] st);
			alloc_result_t e;
			if (pending.size() == 0) begin
				report_mismatch($sformatf("unexpected result base=%h status=%0d", b, st));
				return;
			end
			e = pending.pop_front();
			if (b !== e.base)
				report_mismatch($sformatf("base %h, want %h", b, e.base));
			if (st !== e.status)
				report_mismatch($sformatf("status %0d, want %0d", st, e.status));
		endtask
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_tvalid = 0;
	logic        s_tready;
	logic [63:0] s_tdata = 0;
	logic [1:0]  s_tuser = 0;
	logic        m_tvalid;
	logic        m_tready = 0;
	logic [31:0] m_tdata;
	logic [2:0]  m_tuser;

	region_scoreboard sb = new();
	bit  quiet_phase = 0;
	int  idle_cycles = 0;

	region_table_allocator_unit dut (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				sb.check_result(m_tdata, m_tuser);
			m_tready <= quiet_phase || ($urandom_range(99) >= 16);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("[region_table_allocator_unit] ERROR");
			$finish;
		end
	end

	// tvalid stays up after an accepted transaction until the next call idles or drain
	task automatic send_request(logic [1:0] op, logic [31:0] addr, logic [31:0] sz);
		while (!quiet_phase && $urandom_range(99) < 16) begin
			s_tvalid <= 0;
			@(posedge clk);
		end
		s_tvalid <= 1;
		s_tuser <= op;
		s_tdata <= {sz, addr};
		do @(posedge clk); while (!s_tready);
		sb.note_request(op, addr, sz);
	endtask

	task automatic drain();
		s_tvalid <= 0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
	endtask

	task automatic random_request();
		int          r, k;
		logic [31:0] a, s;
		r = $urandom_range(99);
		k = (sb.count > 0) ? $urandom_range(sb.count - 1) : 0;
		s = $urandom_range(1, 64) << 4;
		if (r < 8) send_request(OP_ADD,
			(sb.count > 0 ? sb.rend[sb.count-1][31:0] : 0) + ($urandom_range(1) ? 0 : 32'h100),
			$urandom_range(1, 2048) << 4);
		else if (r < 35) send_request(OP_ALLOC, $urandom(), s);
		else if (r < 55) begin
			a = sb.count > 0 ? sb.rbeg[k][31:0] + ($urandom_range(0, 8) << 4) : $urandom();
			send_request(OP_ALLOC_AT, a, s);
		end else if (r < 88) send_request(OP_RELEASE,
			sb.count > 0 ? sb.rbeg[k][31:0] : $urandom(), 0);
		else send_request(2'($urandom()), $urandom(), $urandom_range(1) ? 0 : $urandom());
	endtask

	initial begin
		sb.clear();
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: special cases and field extremes
		send_request(OP_RELEASE, 32'h0, 32'h0);
		send_request(OP_ALLOC, 32'h0, 32'h10);
		send_request(OP_ADD, 32'h1000, 32'h0);
		send_request(OP_ADD, 32'hFFFF_FFF0, 32'h20);
		send_request(OP_ADD, 32'h1000, 32'h1000);
		send_request(OP_ADD, 32'h800, 32'h10);
		send_request(OP_ADD, 32'h2000, 32'h1000);
		send_request(OP_ALLOC, 32'hFFFF_FFFF, 32'h0);
		send_request(OP_ALLOC, 32'h0, 32'hFFFF_FFFF);
		send_request(OP_ALLOC, 32'h0, 32'h100);
		send_request(OP_ALLOC_AT, 32'h1800, 32'h100);
		send_request(OP_ALLOC_AT, 32'h1800, 32'h100);
		send_request(OP_ALLOC_AT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(OP_ALLOC_AT, 32'h2000, 32'h0);
		send_request(OP_ALLOC_AT, 32'h2F00, 32'h100);
		send_request(OP_RELEASE, 32'h1800, 32'hFFFF_FFFF);
		send_request(OP_RELEASE, 32'h1800, 32'h0);
		send_request(OP_RELEASE, 32'h1000, 32'h0);
		send_request(OP_RELEASE, 32'h2F00, 32'h0);
		send_request(OP_ADD, 32'hFFFF_F000, 32'h0000_0FFF);
		send_request(OP_ALLOC, 32'h0, 32'h0000_0FFF);
		quiet_phase = 1;
		drain();
		for (int n = 0; n < 1600; n++) begin
			quiet_phase = (n >= 400 && n < 600);
			if (n == 800) drain();
			random_request();
		end
		// fill the table to its limit
		for (int n = 0; n < 40; n++)
			send_request(OP_ADD, sb.count > 0 ? sb.rend[sb.count-1][31:0] : 0, 32'h10);
		for (int n = 0; n < 40; n++) send_request(OP_ALLOC, 0, 32'h8);
		quiet_phase = 1;
		drain();
		repeat (300) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("[region_table_allocator_unit] OK");
		else
			$display("[region_table_allocator_unit] ERROR");
		$finish;
	end
endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/rtau_pkg.sv
rtl/core/region_table_allocator_unit.sv
sim/tb.sv
